@@ design/ipv4_receive_header_checker_unit_defines.svh @@
// ----------------------------------------------------------------------------
// IPv4 receive header checker - assertion macros
// Shared concurrent assertion forms used by the checker RTL.
// ----------------------------------------------------------------------------
`ifndef IPV4_RECEIVE_HEADER_CHECKER_UNIT_DEFINES_SVH
`define IPV4_RECEIVE_HEADER_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define IRHC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ipv4rhc: same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define IRHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ipv4rhc: next-cycle check failed");

`endif

@@ design/ipv4rhc_pkg.sv @@
// ----------------------------------------------------------------------------
// IPv4 receive header checker - package
// Verdict codes, header constants and the structs passed between modules.
// ----------------------------------------------------------------------------
package ipv4rhc_pkg;

    // Verdict codes
    localparam logic [3:0] VERDICT_ICMP     = 4'd0;
    localparam logic [3:0] VERDICT_TCP      = 4'd1;
    localparam logic [3:0] VERDICT_OTHER    = 4'd2;
    localparam logic [3:0] VERDICT_SHORT    = 4'd3;
    localparam logic [3:0] VERDICT_VERSION  = 4'd4;
    localparam logic [3:0] VERDICT_LENGTH   = 4'd5;
    localparam logic [3:0] VERDICT_CHECKSUM = 4'd6;
    localparam logic [3:0] VERDICT_NOT_OURS = 4'd7;
    localparam logic [3:0] VERDICT_OPTIONS  = 4'd8;

    // Header constants
    localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
    localparam logic [7:0]  IHL_MASK         = 8'h0F;
    localparam logic [3:0]  IP_VERSION       = 4'd4;
    localparam logic [7:0]  PROTO_ICMP       = 8'd1;
    localparam logic [7:0]  PROTO_TCP        = 8'd6;
    localparam logic [15:0] GOOD_SUM         = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

    // Header byte offsets
    localparam logic [15:0] POS_VER_IHL  = 16'd0;
    localparam logic [15:0] POS_LEN_HI   = 16'd2;
    localparam logic [15:0] POS_LEN_LO   = 16'd3;
    localparam logic [15:0] POS_PROTO    = 16'd9;
    localparam logic [15:0] POS_SRC_LO   = 16'd12;
    localparam logic [15:0] POS_SRC_HI   = 16'd15;
    localparam logic [15:0] POS_DST_LO   = 16'd16;
    localparam logic [15:0] POS_DST_HI   = 16'd19;

    // Per-packet state as seen after the current beat
    typedef struct packed {
        logic [15:0] byte_count;
        logic [15:0] sum;
        logic [7:0]  ver_ihl;
        logic [15:0] length;
        logic [7:0]  protocol;
        logic [31:0] source;
        logic [31:0] destination;
    } t_hdr_state;

    // One result item
    typedef struct packed {
        logic [3:0]  verdict;
        logic [15:0] total_len;
        logic [15:0] payload_length;
        logic [31:0] source_address;
        logic [7:0]  protocol_number;
    } t_result;

endpackage

@@ design/ipv4rhc_intf.sv @@
// ----------------------------------------------------------------------------
// IPv4 receive header checker - channel interfaces
// Packet byte stream, configuration write and result channels.
// ----------------------------------------------------------------------------
interface ipv4rhc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipv4rhc_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] local_ip_address;

    modport source (output valid, output local_ip_address, input ready);
    modport sink   (input valid, input local_ip_address, output ready);
endinterface

interface ipv4rhc_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  verdict;
    logic [15:0] total_len;
    logic [15:0] payload_length;
    logic [31:0] source_address;
    logic [7:0]  protocol_number;

    modport source (output valid, output verdict, output total_len,
                    output payload_length, output source_address,
                    output protocol_number, input ready);
    modport sink   (input valid, input verdict, input total_len,
                    input payload_length, input source_address,
                    input protocol_number, output ready);
endinterface

@@ design/ipv4rhc_verdict.sv @@
// ----------------------------------------------------------------------------
// IPv4 receive header checker - verdict logic
// Priority checks over the captured header that give the packet verdict.
// ----------------------------------------------------------------------------
module ipv4rhc_verdict (
    input  ipv4rhc_pkg::t_hdr_state i_hdr,
    input  logic [31:0]             i_local_ip,
    output ipv4rhc_pkg::t_result    o_result
);
    import ipv4rhc_pkg::*;

    logic [15:0] hdr_len;
    logic [3:0]  verdict;

    assign hdr_len = {10'd0, (i_hdr.ver_ihl[3:0] & IHL_MASK[3:0]), 2'b00};

    // Run the checks in priority order
    always_comb begin
        if (i_hdr.byte_count < MIN_HEADER_BYTES) begin
            verdict = VERDICT_SHORT;
        end else if (i_hdr.ver_ihl[7:4] != IP_VERSION) begin
            verdict = VERDICT_VERSION;
        end else if ((i_hdr.length > i_hdr.byte_count) || (i_hdr.length < hdr_len)) begin
            verdict = VERDICT_LENGTH;
        end else if ((i_hdr.byte_count < hdr_len) || (i_hdr.sum != GOOD_SUM)) begin
            verdict = VERDICT_CHECKSUM;
        end else if (i_hdr.destination != i_local_ip) begin
            verdict = VERDICT_NOT_OURS;
        end else if (hdr_len != MIN_HEADER_BYTES) begin
            verdict = VERDICT_OPTIONS;
        end else if (i_hdr.protocol == PROTO_ICMP) begin
            verdict = VERDICT_ICMP;
        end else if (i_hdr.protocol == PROTO_TCP) begin
            verdict = VERDICT_TCP;
        end else begin
            verdict = VERDICT_OTHER;
        end
    end

    // Report payload length only for delivered packets
    always_comb begin
        o_result.verdict         = verdict;
        o_result.total_len       = i_hdr.length;
        o_result.source_address  = i_hdr.source;
        o_result.protocol_number = i_hdr.protocol;
        if (verdict <= VERDICT_OTHER) begin
            o_result.payload_length = i_hdr.length - hdr_len;
        end else begin
            o_result.payload_length = 16'd0;
        end
    end

endmodule

@@ design/ipv4_receive_header_checker_unit.sv @@
// ----------------------------------------------------------------------------
// IPv4 receive header checker unit
// Byte-wise IPv4 header capture, checksum and verdict for received packets.
// ----------------------------------------------------------------------------
// The unit accepts one packet byte per clock cycle, with no gaps required
// between bytes or packets. Each byte updates the byte counter, the running
// ones' complement sum and the captured header fields as it is taken; the
// byte flagged as last also loads the verdict into the output register, so
// the result beat appears on the cycle after the last byte is taken and the
// next packet may start at once. The only stall comes from the output
// register: while a result waits and the result channel is not ready, byte
// input is held off. The local address register may be written at any time
// the unit is idle and is always ready.
`include "ipv4_receive_header_checker_unit_defines.svh"

module ipv4_receive_header_checker_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ipv4rhc_cfg_if.sink          i_cfg,
    ipv4rhc_byte_if.sink         i_pkt,
    ipv4rhc_res_if.source        o_res
);
    import ipv4rhc_pkg::*;

    logic [31:0] r_local_ip;
    t_hdr_state  r_hdr;
    t_hdr_state  n_hdr;
    logic [7:0]  r_hold;
    logic [7:0]  n_hold;
    logic        r_out_valid;
    t_result     r_res;
    t_result     verdict_res;

    logic        pkt_accept;
    logic [15:0] pos;
    logic [7:0]  b;
    logic [15:0] hdr_len;
    logic [16:0] word_sum;

    assign pos = r_hdr.byte_count;
    assign b   = i_pkt.data_byte;

    // Take bytes unless a result is waiting on a stalled channel
    assign i_pkt.ready = !r_out_valid || o_res.ready;
    assign pkt_accept  = i_pkt.valid && i_pkt.ready;
    assign i_cfg.ready = 1'b1;

    // Capture header fields and fold the checksum for this beat
    always_comb begin
        n_hdr  = r_hdr;
        n_hold = r_hold;

        if (pos == POS_VER_IHL) begin
            n_hdr.ver_ihl = b;
        end else if (pos == POS_LEN_HI) begin
            n_hdr.length = {b, r_hdr.length[7:0]};
        end else if (pos == POS_LEN_LO) begin
            n_hdr.length = {r_hdr.length[15:8], b};
        end else if (pos == POS_PROTO) begin
            n_hdr.protocol = b;
        end else if ((pos >= POS_SRC_LO) && (pos <= POS_SRC_HI)) begin
            n_hdr.source = {r_hdr.source[23:0], b};
        end else if ((pos >= POS_DST_LO) && (pos <= POS_DST_HI)) begin
            n_hdr.destination = {r_hdr.destination[23:0], b};
        end

        hdr_len  = {10'd0, (n_hdr.ver_ihl[3:0] & IHL_MASK[3:0]), 2'b00};
        word_sum = {1'b0, r_hdr.sum} + {1'b0, r_hold, b};

        if (pos < hdr_len) begin
            if (!pos[0]) begin
                n_hold = b;
            end else begin
                n_hdr.sum = word_sum[15:0] + {15'd0, word_sum[16]};
            end
        end

        if (pos != COUNT_MAX) begin
            n_hdr.byte_count = pos + 16'd1;
        end
    end

    ipv4rhc_verdict u_verdict (
        .i_hdr      (n_hdr),
        .i_local_ip (r_local_ip),
        .o_result   (verdict_res)
    );

    // Hold the local address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip <= 32'd0;
        end else if (i_cfg.valid) begin
            r_local_ip <= i_cfg.local_ip_address;
        end
    end

    // Advance per-packet state, clear it after the last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr  <= '0;
            r_hold <= 8'd0;
        end else if (pkt_accept) begin
            if (i_pkt.last_byte) begin
                r_hdr  <= '0;
                r_hold <= 8'd0;
            end else begin
                r_hdr  <= n_hdr;
                r_hold <= n_hold;
            end
        end
    end

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pkt_accept && i_pkt.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load result payload on the last beat
    always_ff @(posedge i_clk) begin
        if (pkt_accept && i_pkt.last_byte) begin
            r_res <= verdict_res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.verdict         = r_res.verdict;
    assign o_res.total_len       = r_res.total_len;
    assign o_res.payload_length  = r_res.payload_length;
    assign o_res.source_address  = r_res.source_address;
    assign o_res.protocol_number = r_res.protocol_number;

    // Checks on the packet state and result register
    `IRHC_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n,
        pkt_accept && i_pkt.last_byte,
        (r_hdr.byte_count == 16'd0) && o_res.valid)
    `IRHC_ASSERT_NEXT(a_count_advances, i_clk, i_rst_n,
        pkt_accept && !i_pkt.last_byte && (r_hdr.byte_count != COUNT_MAX),
        r_hdr.byte_count == $past(r_hdr.byte_count) + 16'd1)
    `IRHC_ASSERT_SAME(a_drop_payload_len, i_clk, i_rst_n,
        r_out_valid && (r_res.verdict > VERDICT_OTHER),
        r_res.payload_length == 16'd0)
    `IRHC_ASSERT_SAME(a_verdict_range, i_clk, i_rst_n,
        r_out_valid, r_res.verdict <= VERDICT_OPTIONS)

endmodule
